// File: rtl/res_evac_pkg.sv
// Shared types, constants and a helper function for the reservoir evacuation sequencer.
package res_evac_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_INFUSION_MAX    = 3'd0,
    REG_RETURN_RATE_MAX = 3'd1,
    REG_RES_VOLUME      = 3'd2,
    REG_RES_AC_VOLUME   = 3'd3,
    REG_DONOR_BLOOD_ML  = 3'd4,
    REG_MIN_PLASMA_TOT  = 3'd5,
    REG_PLASMA_WIN_LIM  = 3'd6,
    REG_RETURN_WIN_LIM  = 3'd7
  } cfg_reg_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DELTA_W = 15;
  localparam int RATE_W  = 16;
  localparam int ACC_W   = 32;
  localparam int V_W     = 30;          // infusion rate times donor volume
  localparam int MB_W    = 20;          // second multiplier operand
  localparam int NUM_W   = V_W + MB_W;  // dividend width
  localparam int DEN_W   = 34;          // AC volume times the scale factor
  localparam int CNT_W   = $clog2(NUM_W);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 40;

  // Fixed process limits, 0.01 mL or 0.01 mL/min units unless noted.
  localparam logic [ACC_W-1:0]  MAX_PLASMA_TOTAL = 32'd30000;
  localparam logic [RATE_W-1:0] EVAC_PLASMA_RATE = 16'd5000;
  localparam logic [RATE_W-1:0] MIN_INFUSION     = 16'd500;

  localparam logic [MB_W-1:0]   AC_SCALE         = 20'd10000;
  localparam logic [13:0]       DEFAULT_DONOR_ML = 14'd1000;
  localparam logic [ACC_W-1:0]  CUTOUT_RETURN    = 32'd1000;
  localparam logic [ACC_W-1:0]  PRIME_THRESHOLD  = 32'd1500;
  localparam logic [RATE_W-1:0] SLOW_RATE        = 16'd4000;
  localparam logic [15:0]       DOSE_LIMIT       = 16'd100;
  localparam logic [12:0]       RPM_LIMIT        = 13'd200;

  // Signed 32-bit accumulate of a 15-bit delta, saturating at both limits.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]   a,
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + (ACC_W+1)'(d);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

// File: rtl/reservoir_evacuation_sequencer.sv
// Top level of the reservoir evacuation sequencer: rate datapath, accumulators and handshakes.
//
// The block takes one control tick per transfer on the in_ stream and returns one
// command transfer on the out_ stream for each tick. A tick carries the pump volume
// deltas, the reservoir sensor flags, centrifuge speed, red cell dose and the
// operator caps; the result carries the return and plasma pump rates, the red cell
// valve setting and the done flag.
// The return rate is worked out by one shared 30 x 20 bit multiplier used three
// times, then a restoring divider that retires one quotient bit per cycle over a
// 50-bit dividend. That divider sets the pace: a tick goes through the multiply,
// divide, clamp, accumulate and decide steps before its result is loaded, and a new
// tick is taken only after that load, so the block never overlaps two ticks.
// in_tready is high only while the sequencer is idle. The result sits in an output
// register; if the receiver stalls, the next tick is still taken and computed and
// waits in its last step until the output register frees up.
// Configuration writes go through cfg_we/cfg_addr/cfg_wdata and are meant to be
// done while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults, clears all
// accumulators and sequencer flags and empties the output register.
module reservoir_evacuation_sequencer
  import res_evac_pkg::*;
#(
  parameter logic [ACC_W-1:0]  MAX_PLASMA_TOT    = MAX_PLASMA_TOTAL,
  parameter logic [RATE_W-1:0] EVAC_RATE         = EVAC_PLASMA_RATE,
  parameter logic [RATE_W-1:0] MIN_INFUSION_RATE = MIN_INFUSION
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Tick input, fields from bit 0 up: plasma_delta[14:0], return_delta[14:0],
  // reservoir_full, reservoir_empty, safety_reservoir_empty, centrifuge_rpm[12:0],
  // red_cell_dose[15:0], infusion_cap[15:0], return_cap[15:0], two zero bits.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result, fields from bit 0 up: return_pump_rate[15:0], plasma_pump_rate[15:0],
  // rbc_valve_collect, done_res, six zero bits.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_V,
    S_MUL_N,
    S_MUL_D,
    S_DIV,
    S_CLAMP,
    S_ACC,
    S_DECIDE,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] infusion_max_r, return_rate_max_r;
  logic [19:0] res_volume_r, res_ac_volume_r;
  logic [13:0] donor_ml_r;
  logic [19:0] min_plasma_total_r, plasma_win_lim_r, return_win_lim_r;

  // Latched tick fields.
  logic signed [DELTA_W-1:0] pdel_r, rdel_r;
  logic        full_r, empty_r, safe_empty_r, collect_r;
  logic [15:0] rcap_r;

  // Rate datapath.
  logic [RATE_W-1:0] ir_r;
  logic [V_W-1:0]    v_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RATE_W-1:0] rate_r;

  // Sequencer state.
  logic signed [ACC_W-1:0] win_plasma_r, win_return_r, total_plasma_r;
  logic signed [ACC_W-1:0] return_since_full_r, prime_volume_r;
  logic full_cutout_r, over_total_r, primed_r, finished_r;
  logic [RATE_W-1:0] qp_r, qr_r;

  // Output register.
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // Input field views.
  logic signed [DELTA_W-1:0] in_pdel, in_rdel;
  logic [12:0] in_rpm;
  logic [15:0] in_dose, in_icap, in_rcap;
  logic [15:0] ir_min, ir_sel;

  assign in_pdel = in_tdata[14:0];
  assign in_rdel = in_tdata[29:15];
  assign in_rpm  = in_tdata[45:33];
  assign in_dose = in_tdata[61:46];
  assign in_icap = in_tdata[77:62];
  assign in_rcap = in_tdata[93:78];

  // Permitted infusion rate: the tighter of the two caps, but never below the floor.
  assign ir_min = (infusion_max_r > in_icap) ? in_icap : infusion_max_r;
  assign ir_sel = (ir_min < MIN_INFUSION_RATE) ? MIN_INFUSION_RATE : ir_min;

  // The one multiplier, shared by the three products of the rate formula.
  logic [V_W-1:0]   mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [NUM_W-1:0] prod;
  logic             ac_zero;

  assign ac_zero = (res_ac_volume_r == '0);

  always_comb begin
    unique case (state_r)
      S_MUL_V: begin
        mul_a = V_W'(ir_r);
        mul_b = MB_W'((donor_ml_r == '0) ? DEFAULT_DONOR_ML : donor_ml_r);
      end
      S_MUL_N: begin
        mul_a = v_r;
        mul_b = res_volume_r;
      end
      S_MUL_D: begin
        mul_a = V_W'(res_ac_volume_r);
        mul_b = AC_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

  // One restoring divide step.
  logic [DEN_W:0]   div_shift;
  logic [DEN_W+1:0] div_diff;
  logic             div_ge;
  logic [DEN_W-1:0] rem_nxt;

  assign div_shift = {rem_r, num_r[NUM_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_r};
  assign div_ge    = !div_diff[DEN_W+1];
  assign rem_nxt   = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];

  // Caps on the quotient.
  logic [RATE_W-1:0] q_rcap, q_final;
  assign q_rcap  = (num_r > NUM_W'(rcap_r)) ? rcap_r : num_r[RATE_W-1:0];
  assign q_final = (q_rcap > return_rate_max_r) ? return_rate_max_r : q_rcap;

  // First update step: cutout release, priming and accumulation.
  logic              fc_acc, primed_acc;
  logic signed [ACC_W-1:0] prime_acc;
  logic [RATE_W-1:0] qp_acc, qr_acc;

  always_comb begin
    fc_acc     = full_cutout_r;
    primed_acc = primed_r;
    prime_acc  = prime_volume_r;
    if (full_cutout_r && (return_since_full_r < $signed(CUTOUT_RETURN))) begin
      qp_acc = '0;
    end else begin
      fc_acc = 1'b0;
      qp_acc = over_total_r ? '0 : EVAC_RATE;
    end
    if (!primed_r) begin
      prime_acc = sat_add(prime_volume_r, pdel_r);
      if ((prime_acc >= $signed(PRIME_THRESHOLD)) || over_total_r) begin
        primed_acc = 1'b1;
        prime_acc  = '0;
      end
    end
    if (safe_empty_r) begin
      primed_acc = 1'b0;
      qr_acc     = '0;
    end else begin
      qr_acc = (primed_acc || fc_acc) ? rate_r : '0;
    end
  end

  // Second update step: window checks, total limit, sensor trip and done flag.
  logic window_hit, return_low, over_total_dec, finished_dec;

  assign window_hit = (total_plasma_r > $signed(ACC_W'(min_plasma_total_r))) &&
                      (win_plasma_r >= $signed(ACC_W'(plasma_win_lim_r)));
  assign return_low = (win_return_r < $signed(ACC_W'(return_win_lim_r)));
  assign over_total_dec = over_total_r || (total_plasma_r > $signed(MAX_PLASMA_TOT));
  assign finished_dec = finished_r || (window_hit && return_low) ||
                        (empty_r && (rate_r != '0) && (rate_r < SLOW_RATE)) ||
                        (empty_r && over_total_dec);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      infusion_max_r      <= 16'd1200;
      return_rate_max_r   <= 16'd9000;
      res_volume_r        <= '0;
      res_ac_volume_r     <= '0;
      donor_ml_r          <= 14'd5000;
      min_plasma_total_r  <= '0;
      plasma_win_lim_r    <= '0;
      return_win_lim_r    <= '0;
      win_plasma_r        <= '0;
      win_return_r        <= '0;
      total_plasma_r      <= '0;
      return_since_full_r <= '0;
      prime_volume_r      <= '0;
      full_cutout_r       <= 1'b0;
      over_total_r        <= 1'b0;
      primed_r            <= 1'b0;
      finished_r          <= 1'b0;
      rate_r              <= '0;
      out_tvalid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_INFUSION_MAX:    infusion_max_r     <= cfg_wdata[15:0];
          REG_RETURN_RATE_MAX: return_rate_max_r  <= cfg_wdata[15:0];
          REG_RES_VOLUME:      res_volume_r       <= cfg_wdata;
          REG_RES_AC_VOLUME:   res_ac_volume_r    <= cfg_wdata;
          REG_DONOR_BLOOD_ML:  donor_ml_r         <= cfg_wdata[13:0];
          REG_MIN_PLASMA_TOT:  min_plasma_total_r <= cfg_wdata;
          REG_PLASMA_WIN_LIM:  plasma_win_lim_r   <= cfg_wdata;
          REG_RETURN_WIN_LIM:  return_win_lim_r   <= cfg_wdata;
        endcase
      end

      // A result loaded in S_OUT takes the place of the one leaving, so valid
      // is only dropped here when nothing new is loaded.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pdel_r       <= in_pdel;
            rdel_r       <= in_rdel;
            full_r       <= in_tdata[30];
            empty_r      <= in_tdata[31];
            safe_empty_r <= in_tdata[32];
            collect_r    <= (in_dose < DOSE_LIMIT) && (in_rpm < RPM_LIMIT);
            rcap_r       <= in_rcap;
            ir_r         <= ir_sel;
            state_r      <= S_MUL_V;
          end
        end
        S_MUL_V: begin
          v_r     <= prod[V_W-1:0];
          state_r <= S_MUL_N;
        end
        S_MUL_N: begin
          num_r   <= ac_zero ? NUM_W'(v_r) : prod;
          state_r <= S_MUL_D;
        end
        S_MUL_D: begin
          den_r   <= ac_zero ? DEN_W'(AC_SCALE) : prod[DEN_W-1:0];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          num_r <= {num_r[NUM_W-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          rate_r  <= q_final;
          state_r <= S_ACC;
        end
        S_ACC: begin
          full_cutout_r       <= fc_acc;
          primed_r            <= primed_acc;
          prime_volume_r      <= prime_acc;
          qp_r                <= qp_acc;
          qr_r                <= qr_acc;
          win_return_r        <= sat_add(win_return_r, rdel_r);
          win_plasma_r        <= sat_add(win_plasma_r, pdel_r);
          total_plasma_r      <= sat_add(total_plasma_r, pdel_r);
          return_since_full_r <= sat_add(return_since_full_r, rdel_r);
          state_r             <= S_DECIDE;
        end
        S_DECIDE: begin
          if (window_hit && !return_low) begin
            win_return_r <= '0;
            win_plasma_r <= '0;
          end
          over_total_r <= over_total_dec;
          if (full_r && !full_cutout_r) begin
            full_cutout_r       <= 1'b1;
            return_since_full_r <= '0;
          end
          finished_r <= finished_dec;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'b0, finished_r, collect_r, qp_r, qr_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
